### rtl/psws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psws_pkg
// Shared constants for the sweep-width statistics block.
// ----------------------------------------------------------------------------
package psws_pkg;
    localparam int MAX_CELLS   = 32;
    localparam int CELL_LIMIT  = (MAX_CELLS < 63) ? MAX_CELLS : 63;
    localparam int NSIZES      = 33;
    localparam int NBINS       = 33;
    localparam int HIST_DEPTH  = NSIZES * NBINS;
    localparam int HIST_AW     = $clog2(HIST_DEPTH);
    localparam int SIZE_AW     = $clog2(NSIZES);
    localparam int DIAG_DEPTH  = 128;
    localparam int DIAG_AW     = $clog2(DIAG_DEPTH);
    localparam int EPOCH_W     = 8;
    localparam int CNT_W       = 63;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [5:0] MAX_SIZE_RESET = 6'd32;
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_READ = 1'b1;
endpackage

### rtl/polyplet_sweep_width_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyplet_sweep_width_stats
// Per-animal sweep widths and per-size statistics over lattice animals.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per cell
//   (action = add) or a statistics read (action = read). The output channel
//   (out_valid/out_ready) returns one transaction for a last cell or a read,
//   none for other cells. One item is in flight at a time.
//   Steps: a cell passes through accept, diagonal-counter read and write back;
//   a cell beyond the cell limit that is not last is only accepted. A last cell
//   adds a statistics read and a statistics write back, which registers the
//   result and raises out_valid. A read passes through accept, a memory wait
//   and a read state. The synchronous memories set these steps.
//   Diagonal counters are cleared per animal by an 8-bit epoch mark; after the
//   result of every 255th animal is taken, a wipe pass clears them.
//   Reset: after rst_n releases, a clearing pass zeroes the statistics and
//   diagonal memories; no item is accepted during it. max_size
//   resets to 32 and may be written at any time the block is idle.
//   When the receiver stalls, the result is held in the output register and
//   the block accepts no new item until it is taken.
// ----------------------------------------------------------------------------
module polyplet_sweep_width_stats (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic signed [5:0] cell_x,
    input  logic [4:0]  cell_y,
    input  logic        last_cell,
    input  logic [5:0]  query_size,
    input  logic [5:0]  query_bin,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  n_cells,
    output logic [5:0]  row_extent,
    output logic [5:0]  col_extent,
    output logic [6:0]  main_diag_extent,
    output logic [6:0]  anti_diag_extent,
    output logic [5:0]  main_diag_occupancy,
    output logic [5:0]  anti_diag_occupancy,
    output logic [5:0]  min_extent,
    output logic [5:0]  min_occupancy,
    output logic        counted,
    output logic [62:0] animal_count,
    output logic [62:0] hist_count
);
    import psws_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CELL_RD, S_CELL_WR, S_STAT_RD, S_STAT_WR, S_QRY_WT,
        S_QRY_RD, S_OUT, S_WIPE
    } state_t;

    state_t state_reg;
    logic [5:0] max_size_reg;

    // diagonal counters: entry = {epoch, count}; epoch 0 marks a wiped entry
    logic [EPOCH_W+5:0] mdiag_mem [0:DIAG_DEPTH-1];
    logic [EPOCH_W+5:0] adiag_mem [0:DIAG_DEPTH-1];
    logic [EPOCH_W+5:0] mdiag_q, adiag_q;
    logic [EPOCH_W-1:0] epoch_reg;
    logic               wipe_reg;

    // statistics memories
    logic [CNT_W-1:0] size_mem [0:NSIZES-1];
    logic [11:0]      mx_mem   [0:NSIZES-1];   // {max ext, max occ}
    logic [CNT_W-1:0] hist_mem [0:HIST_DEPTH-1];
    logic [CNT_W-1:0] size_q, hist_q;
    logic [11:0]      mx_q;

    logic [HIST_AW-1:0] clr_reg;

    logic [5:0] cnt_reg;
    logic signed [5:0] xmin_reg, xmax_reg;
    logic [4:0] ymin_reg, ymax_reg;
    logic signed [6:0] dmin_reg, dmax_reg, amin_reg, amax_reg;
    logic [5:0] pm_reg, pa_reg;
    logic [6:0] im_reg, ia_reg;
    logic       last_reg;
    logic [SIZE_AW-1:0] sidx_reg;
    logic [HIST_AW-1:0] hidx_reg;
    logic       qsv_reg, qbv_reg;

    // per-animal measures
    logic [5:0] rows_c, cols_c, mext_c, mocc_c, min_rc;
    logic [6:0] dm_c, da_c, cols_w;
    logic       cnt_ok;
    always_comb
    begin
        rows_c = 6'(ymax_reg - ymin_reg) + 6'd1;
        cols_w = 7'(xmax_reg - xmin_reg) + 7'd1;
        cols_c = (cols_w > 7'd63) ? 6'd63 : cols_w[5:0];
        dm_c   = 7'(dmax_reg - dmin_reg + 7'sd1);
        da_c   = 7'(amax_reg - amin_reg + 7'sd1);
        min_rc = (rows_c < cols_c) ? rows_c : cols_c;
        mext_c = min_rc;
        if ({1'b0, mext_c} > dm_c) mext_c = dm_c[5:0];
        if ({1'b0, mext_c} > da_c) mext_c = da_c[5:0];
        mocc_c = min_rc;
        if (mocc_c > pm_reg) mocc_c = pm_reg;
        if (mocc_c > pa_reg) mocc_c = pa_reg;
        if (cnt_reg == 6'd0)
        begin
            rows_c = '0; cols_c = '0; dm_c = '0; da_c = '0; mext_c = '0; mocc_c = '0;
        end
        cnt_ok = (cnt_reg != 6'd0) && (cnt_reg <= max_size_reg)
                 && (cnt_reg < 6'(NSIZES));
    end

    // new cell values
    logic signed [6:0] dm_in, da_in;
    logic [5:0] mc_new, ac_new;
    assign dm_in  = 7'(cell_x) - 7'(signed'({1'b0, cell_y}));
    assign da_in  = 7'(cell_x) + 7'(signed'({1'b0, cell_y}));
    assign mc_new = ((mdiag_q[EPOCH_W+5:6] == epoch_reg) ? mdiag_q[5:0] : 6'd0) + 6'd1;
    assign ac_new = ((adiag_q[EPOCH_W+5:6] == epoch_reg) ? adiag_q[5:0] : 6'd0) + 6'd1;

    // histogram address of the finished animal
    logic [HIST_AW-1:0] hsum;
    assign hsum = HIST_AW'(cnt_reg) * HIST_AW'(NBINS) + HIST_AW'(mext_c);

    assign in_ready = (state_reg == S_IDLE);

    // memories
    always_ff @(posedge clk)
    begin
        mdiag_q <= mdiag_mem[im_reg];
        adiag_q <= adiag_mem[ia_reg];
        if (state_reg == S_CELL_WR)
        begin
            mdiag_mem[im_reg] <= {epoch_reg, mc_new};
            adiag_mem[ia_reg] <= {epoch_reg, ac_new};
        end
        else if ((state_reg == S_CLEAR && clr_reg < HIST_AW'(DIAG_DEPTH))
                 || state_reg == S_WIPE)
        begin
            mdiag_mem[clr_reg[DIAG_AW-1:0]] <= '0;
            adiag_mem[clr_reg[DIAG_AW-1:0]] <= '0;
        end
        size_q <= size_mem[sidx_reg];
        mx_q   <= mx_mem[sidx_reg];
        hist_q <= hist_mem[hidx_reg];
        if (state_reg == S_CLEAR)
        begin
            hist_mem[clr_reg] <= '0;
            if (clr_reg < HIST_AW'(NSIZES))
            begin
                size_mem[clr_reg[SIZE_AW-1:0]] <= '0;
                mx_mem[clr_reg[SIZE_AW-1:0]]   <= '0;
            end
        end
        else if (state_reg == S_STAT_WR && cnt_ok)
        begin
            size_mem[sidx_reg] <= (size_q == CNT_MAX) ? size_q : size_q + 1'b1;
            mx_mem[sidx_reg] <= {(mext_c > mx_q[11:6]) ? mext_c : mx_q[11:6],
                                 (mocc_c > mx_q[5:0]) ? mocc_c : mx_q[5:0]};
            if (mext_c < 6'(NBINS))
                hist_mem[hidx_reg] <= (hist_q == CNT_MAX) ? hist_q : hist_q + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            max_size_reg <= MAX_SIZE_RESET;
            clr_reg      <= '0;
            epoch_reg    <= EPOCH_W'(1);
            wipe_reg     <= 1'b0;
            cnt_reg      <= '0;
            pm_reg       <= '0;
            pa_reg       <= '0;
            out_valid    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                max_size_reg <= cfg_wdata;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == HIST_AW'(HIST_DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (action == ACT_READ)
                        begin
                            qsv_reg  <= query_size < 6'(NSIZES);
                            qbv_reg  <= query_bin < 6'(NBINS);
                            sidx_reg <= query_size[SIZE_AW-1:0];
                            hidx_reg <= HIST_AW'(query_size[SIZE_AW-1:0])
                                        * HIST_AW'(NBINS) + HIST_AW'(query_bin);
                            state_reg <= S_QRY_WT;
                        end
                        else
                        begin
                            last_reg <= last_cell;
                            if (cnt_reg < 6'(CELL_LIMIT))
                            begin
                                im_reg <= dm_in;
                                ia_reg <= da_in;
                                if (cnt_reg == 6'd0)
                                begin
                                    xmin_reg <= cell_x; xmax_reg <= cell_x;
                                    ymin_reg <= cell_y; ymax_reg <= cell_y;
                                    dmin_reg <= dm_in;  dmax_reg <= dm_in;
                                    amin_reg <= da_in;  amax_reg <= da_in;
                                end
                                else
                                begin
                                    if (cell_x < xmin_reg) xmin_reg <= cell_x;
                                    if (cell_x > xmax_reg) xmax_reg <= cell_x;
                                    if (cell_y < ymin_reg) ymin_reg <= cell_y;
                                    if (cell_y > ymax_reg) ymax_reg <= cell_y;
                                    if (dm_in < dmin_reg) dmin_reg <= dm_in;
                                    if (dm_in > dmax_reg) dmax_reg <= dm_in;
                                    if (da_in < amin_reg) amin_reg <= da_in;
                                    if (da_in > amax_reg) amax_reg <= da_in;
                                end
                                cnt_reg   <= cnt_reg + 6'd1;
                                state_reg <= S_CELL_RD;
                            end
                            else if (last_cell)
                            begin
                                sidx_reg  <= cnt_reg[SIZE_AW-1:0];
                                hidx_reg  <= hsum;
                                state_reg <= S_STAT_RD;
                            end
                        end
                    end
                end
                S_CELL_RD:
                    state_reg <= S_CELL_WR;
                S_CELL_WR:
                begin
                    if (mc_new > pm_reg) pm_reg <= mc_new;
                    if (ac_new > pa_reg) pa_reg <= ac_new;
                    sidx_reg  <= cnt_reg[SIZE_AW-1:0];
                    hidx_reg  <= hsum;
                    state_reg <= last_reg ? S_STAT_RD : S_IDLE;
                end
                S_STAT_RD:
                    state_reg <= S_STAT_WR;
                S_STAT_WR:
                begin
                    n_cells             <= cnt_reg;
                    row_extent          <= rows_c;
                    col_extent          <= cols_c;
                    main_diag_extent    <= dm_c;
                    anti_diag_extent    <= da_c;
                    main_diag_occupancy <= pm_reg;
                    anti_diag_occupancy <= pa_reg;
                    min_extent          <= mext_c;
                    min_occupancy       <= mocc_c;
                    counted             <= cnt_ok;
                    animal_count        <= '0;
                    hist_count          <= '0;
                    out_valid           <= 1'b1;
                    cnt_reg             <= '0;
                    pm_reg              <= '0;
                    pa_reg              <= '0;
                    // epoch wraps: stale marks would alias, wipe the counters
                    if (epoch_reg == {EPOCH_W{1'b1}})
                    begin
                        epoch_reg <= EPOCH_W'(1);
                        wipe_reg  <= 1'b1;
                        clr_reg   <= '0;
                    end
                    else
                        epoch_reg <= epoch_reg + EPOCH_W'(1);
                    state_reg           <= S_OUT;
                end
                S_QRY_WT:
                    state_reg <= S_QRY_RD;
                S_QRY_RD:
                begin
                    n_cells             <= '0;
                    row_extent          <= '0;
                    col_extent          <= '0;
                    main_diag_extent    <= '0;
                    anti_diag_extent    <= '0;
                    main_diag_occupancy <= '0;
                    anti_diag_occupancy <= '0;
                    counted             <= 1'b0;
                    min_extent          <= qsv_reg ? mx_q[11:6] : 6'd0;
                    min_occupancy       <= qsv_reg ? mx_q[5:0] : 6'd0;
                    animal_count        <= qsv_reg ? size_q : '0;
                    hist_count          <= (qsv_reg && qbv_reg) ? hist_q : '0;
                    out_valid           <= 1'b1;
                    state_reg           <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= wipe_reg ? S_WIPE : S_IDLE;
                    end
                end
                S_WIPE:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == HIST_AW'(DIAG_DEPTH - 1))
                    begin
                        wipe_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives lattice-animal cells and statistics reads into the sweep-width block,
// predicts each result from a shadow model of its state and checks the
// results in order, with random idle bursts on both channels before the last phase.
// ----------------------------------------------------------------------------
module tb_top;
    import psws_pkg::*;

    typedef struct packed {
        logic [5:0]  n_cells;
        logic [5:0]  row_extent;
        logic [5:0]  col_extent;
        logic [6:0]  main_diag_extent;
        logic [6:0]  anti_diag_extent;
        logic [5:0]  main_diag_occupancy;
        logic [5:0]  anti_diag_occupancy;
        logic [5:0]  min_extent;
        logic [5:0]  min_occupancy;
        logic        counted;
        logic [62:0] animal_count;
        logic [62:0] hist_count;
    } sweep_res_t;

    class sweep_scoreboard;
        sweep_res_t  expected_q[$];
        int          errors;
        logic [5:0]  max_size;
        int          n_seen;
        int          xmin, xmax, ymin, ymax, dmin, dmax, amin, amax;
        int          peak_m, peak_a;
        int          mcnt[128];
        int          acnt[128];
        logic [62:0] size_cnt[NSIZES];
        int          ext_max[NSIZES];
        int          occ_max[NSIZES];
        logic [62:0] hist[NSIZES][NBINS];

        function new();
            errors = 0;
            max_size = MAX_SIZE_RESET;
            foreach (size_cnt[i])
            begin
                size_cnt[i] = '0;
                ext_max[i] = 0;
                occ_max[i] = 0;
                foreach (hist[i][j])
                    hist[i][j] = '0;
            end
            clear_animal();
        endfunction

        function void clear_animal();
            n_seen = 0;
            peak_m = 0;
            peak_a = 0;
            foreach (mcnt[i])
            begin
                mcnt[i] = 0;
                acnt[i] = 0;
            end
        endfunction

        function logic [62:0] sat_inc(logic [62:0] v);
            return (v == CNT_MAX) ? v : v + 63'd1;
        endfunction

        function int imin(int a, int b);
            return (a < b) ? a : b;
        endfunction

        function void add_cell(int x, int y);
            int dm, da, im, ia;
            dm = x - y;
            da = x + y;
            im = (dm + 64) & 127;
            ia = (da + 64) & 127;
            if (n_seen >= CELL_LIMIT)
                return;
            if (n_seen == 0)
            begin
                xmin = x; xmax = x; ymin = y; ymax = y;
                dmin = dm; dmax = dm; amin = da; amax = da;
            end
            else
            begin
                if (x < xmin) xmin = x;
                if (x > xmax) xmax = x;
                if (y < ymin) ymin = y;
                if (y > ymax) ymax = y;
                if (dm < dmin) dmin = dm;
                if (dm > dmax) dmax = dm;
                if (da < amin) amin = da;
                if (da > amax) amax = da;
            end
            n_seen++;
            mcnt[im]++;
            acnt[ia]++;
            if (mcnt[im] > peak_m) peak_m = mcnt[im];
            if (acnt[ia] > peak_a) peak_a = acnt[ia];
        endfunction

        // accepted input transaction
        function void note(logic act, logic signed [5:0] cx, logic [4:0] cy, logic lst,
                           logic [5:0] qs, logic [5:0] qb);
            sweep_res_t r;
            int rows, cols, dmain, danti, m_ext, m_occ;
            r = '0;
            if (act == ACT_READ)
            begin
                if (qs < NSIZES)
                begin
                    r.min_extent = 6'(ext_max[qs]);
                    r.min_occupancy = 6'(occ_max[qs]);
                    r.animal_count = size_cnt[qs];
                    if (qb < NBINS)
                        r.hist_count = hist[qs][qb];
                end
                expected_q = {expected_q, r};
                return;
            end
            add_cell(int'(cx), int'(cy));
            if (!lst)
                return;
            rows = 0; cols = 0; dmain = 0; danti = 0; m_ext = 0; m_occ = 0;
            if (n_seen > 0)
            begin
                rows = ymax - ymin + 1;
                cols = xmax - xmin + 1;
                if (cols > 63) cols = 63;
                dmain = dmax - dmin + 1;
                danti = amax - amin + 1;
                m_ext = imin(imin(rows, cols), imin(dmain, danti));
                m_occ = imin(imin(rows, cols), imin(peak_m, peak_a));
            end
            if (n_seen >= 1 && n_seen <= max_size && n_seen < NSIZES)
            begin
                r.counted = 1'b1;
                size_cnt[n_seen] = sat_inc(size_cnt[n_seen]);
                if (m_ext > ext_max[n_seen]) ext_max[n_seen] = m_ext;
                if (m_occ > occ_max[n_seen]) occ_max[n_seen] = m_occ;
                if (m_ext < NBINS)
                    hist[n_seen][m_ext] = sat_inc(hist[n_seen][m_ext]);
            end
            r.n_cells = 6'(n_seen);
            r.row_extent = 6'(rows);
            r.col_extent = 6'(cols);
            r.main_diag_extent = 7'(dmain);
            r.anti_diag_extent = 7'(danti);
            r.main_diag_occupancy = 6'(peak_m);
            r.anti_diag_occupancy = 6'(peak_a);
            r.min_extent = 6'(m_ext);
            r.min_occupancy = 6'(m_occ);
            expected_q = {expected_q, r};
            clear_animal();
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task cmp(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        task check(sweep_res_t got);
            sweep_res_t w;
            if (expected_q.size() == 0)
            begin
                report("result with no transaction pending");
                return;
            end
            w = expected_q.pop_front();
            cmp("n_cells", 64'(got.n_cells), 64'(w.n_cells));
            cmp("row_extent", 64'(got.row_extent), 64'(w.row_extent));
            cmp("col_extent", 64'(got.col_extent), 64'(w.col_extent));
            cmp("main_diag_extent", 64'(got.main_diag_extent),
                64'(w.main_diag_extent));
            cmp("anti_diag_extent", 64'(got.anti_diag_extent),
                64'(w.anti_diag_extent));
            cmp("main_diag_occupancy", 64'(got.main_diag_occupancy),
                64'(w.main_diag_occupancy));
            cmp("anti_diag_occupancy", 64'(got.anti_diag_occupancy),
                64'(w.anti_diag_occupancy));
            cmp("min_extent", 64'(got.min_extent), 64'(w.min_extent));
            cmp("min_occupancy", 64'(got.min_occupancy), 64'(w.min_occupancy));
            cmp("counted", 64'(got.counted), 64'(w.counted));
            cmp("animal_count", 64'(got.animal_count), 64'(w.animal_count));
            cmp("hist_count", 64'(got.hist_count), 64'(w.hist_count));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [5:0]  cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = ACT_ADD;
    logic signed [5:0] cell_x = '0;
    logic [4:0]  cell_y = '0;
    logic        last_cell = 1'b0;
    logic [5:0]  query_size = '0;
    logic [5:0]  query_bin = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    wire sweep_res_t res;

    sweep_scoreboard sb = new();
    bit idling = 1'b1;
    bit in_took = 1'b0;
    int out_hold = 0;
    int walk_x, walk_y;

    always #4 clk = ~clk;

    polyplet_sweep_width_stats DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .action(action),
        .cell_x(cell_x), .cell_y(cell_y), .last_cell(last_cell),
        .query_size(query_size), .query_bin(query_bin),
        .out_valid(out_valid), .out_ready(out_ready),
        .n_cells(res.n_cells), .row_extent(res.row_extent),
        .col_extent(res.col_extent), .main_diag_extent(res.main_diag_extent),
        .anti_diag_extent(res.anti_diag_extent),
        .main_diag_occupancy(res.main_diag_occupancy),
        .anti_diag_occupancy(res.anti_diag_occupancy),
        .min_extent(res.min_extent), .min_occupancy(res.min_occupancy),
        .counted(res.counted), .animal_count(res.animal_count),
        .hist_count(res.hist_count)
    );

    always @(posedge clk)
    begin
        if (cfg_we)
            sb.max_size = cfg_wdata;
        if (in_valid && in_ready)
        begin
            sb.note(action, cell_x, cell_y, last_cell, query_size, query_bin);
            in_took = 1'b1;
        end
        if (out_valid && out_ready)
            sb.check(res);
    end

    // receiver stalls in bursts
    always @(negedge clk)
    begin
        if (out_hold > 0)
            out_hold--;
        else if (idling && $urandom_range(0, 3) == 0)
            out_hold = $urandom_range(1, 5);
        out_ready = (out_hold == 0);
    end

    task send(logic act, logic signed [5:0] cx, logic [4:0] cy, logic lst,
              logic [5:0] qs, logic [5:0] qb);
        int gap;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        action = act; cell_x = cx; cell_y = cy; last_cell = lst;
        query_size = qs; query_bin = qb;
        in_valid = 1'b1;
        in_took = 1'b0;
        do @(negedge clk); while (!in_took);
    endtask

    task add(int x, int y, bit lst);
        send(ACT_ADD, 6'(x), 5'(y), lst, 6'($urandom), 6'($urandom));
    endtask

    task read_stats(int qs, int qb);
        send(ACT_READ, 6'($urandom), 5'($urandom), 1'($urandom), 6'(qs), 6'(qb));
    endtask

    // drain all results, then allow the last cell's trailing work to finish
    task settle();
        in_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task write_max_size(logic [5:0] v);
        settle();
        cfg_wdata = v;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task random_read();
        if ($urandom_range(0, 4) == 0)
            read_stats($urandom_range(0, 63), $urandom_range(0, 63));
        else
            read_stats($urandom_range(0, 33), $urandom_range(0, 33));
    endtask

    task random_animal();
        int sz, k, sel;
        bit scatter;
        sel = $urandom_range(0, 19);
        if (sel < 14)       sz = $urandom_range(1, 8);
        else if (sel < 18)  sz = $urandom_range(9, 32);
        else                sz = $urandom_range(33, 40);
        scatter = ($urandom_range(0, 3) == 0);
        walk_x = $urandom_range(0, 63) - 32;
        walk_y = $urandom_range(0, 31);
        for (k = 0; k < sz; k++)
        begin
            if (scatter)
            begin
                walk_x = $urandom_range(0, 63) - 32;
                walk_y = $urandom_range(0, 31);
            end
            else
            begin
                walk_x = walk_x + $urandom_range(0, 2) - 1;
                walk_y = walk_y + $urandom_range(0, 2) - 1;
                if (walk_x < -32) walk_x = -32;
                if (walk_x > 31) walk_x = 31;
                if (walk_y < 0) walk_y = 0;
                if (walk_y > 31) walk_y = 31;
            end
            add(walk_x, walk_y, k == sz - 1);
            if ($urandom_range(0, 15) == 0)
                random_read();
        end
    endtask

    task random_phase(int n);
        int start;
        start = 0;
        while (start < n)
        begin
            if ($urandom_range(0, 9) < 7)
                random_animal();
            else
                random_read();
            start++;
            if ($urandom_range(0, 150) == 0)
                settle();
        end
    endtask

    initial
    begin
        logic [5:0] settings[7];
        int p;
        settings = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd5, 6'd32, 6'd0};
        settings[6] = 6'($urandom_range(1, 32));
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        write_max_size(settings[0]);
        // directed: corners, wide span, read while an animal is open, odd queries
        add(-32, 0, 1);
        add(31, 31, 1);
        add(-32, 31, 0);
        add(31, 0, 1);
        add(-32, 0, 0);
        add(31, 31, 1);
        add(0, 0, 0);
        read_stats(1, 1);
        add(0, 0, 0);
        add(1, 1, 1);
        read_stats(0, 0);
        read_stats(2, 1);
        read_stats(2, 33);
        read_stats(33, 0);
        read_stats(63, 63);
        read_stats(32, 32);
        read_stats(1, 0);
        add(-1, 5, 0);
        add(-1, 6, 0);
        add(-1, 7, 1);
        read_stats(3, 1);

        for (p = 0; p < 7; p++)
        begin
            if (p != 0)
                write_max_size(settings[p]);
            if (p == 6)
                idling = 1'b0;
            random_phase(22);
            settle();
            random_read();
        end

        settle();
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("tb_top: errors");
        $finish;
    end
endmodule
